// ===== design/scc_pkg.sv =====
// Package with the constants and types of the spike cross-correlogram block.
`default_nettype none
package scc_pkg;
  localparam int unsigned MaxRefSpikes = 1024;
  localparam int unsigned MaxTgtSpikes = 1024;
  localparam int unsigned MaxBinsDef   = 64;
  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned CountWidth   = 21;
  localparam int unsigned BinIdxWidth  = 6;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef enum logic [1:0] {
    OpLoadRef  = 2'd0,
    OpLoadTgt  = 2'd1,
    OpLoadEdge = 2'd2,
    OpCompute  = 2'd3
  } opcode_e;
endpackage
`default_nettype wire

// ===== design/scc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module scc_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 1024,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/spike_cross_correlogram.sv =====
// Top level of the spike cross-correlogram block.
//
// One input channel carries beats of opcode and time_value. Loads of
// reference spikes, target spikes and bin edges give no result; a load
// into a full store is dropped.
// A compute beat walks, for every bin, every reference spike and, for each,
// every target spike held in the spike memories, one pair per cycle but for
// a pause before each further reference spike while its window is formed,
// the edges read first from the edge memory; when a spike store is empty
// the pair walk is skipped. Each bin's result beat is sent after its walk;
// the last carries last_bin.
// With no bin edge or only one loaded, a single beat flags no_bins.
// No input beat is taken while a compute runs or results are pending.
// A stalled receiver holds the output register; the walk waits for it.
// After reset all counts are zero; stores need no clearing pass, as only
// entries below the counts are read. Compute clears the counts.
`default_nettype none
module spike_cross_correlogram #(
  parameter int unsigned MAX_REFERENCE_SPIKES = scc_pkg::MaxRefSpikes,
  parameter int unsigned MAX_TARGET_SPIKES    = scc_pkg::MaxTgtSpikes,
  parameter int unsigned MAX_BINS             = scc_pkg::MaxBinsDef,
  parameter int unsigned TIME_WIDTH           = scc_pkg::TimeWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic signed [TIME_WIDTH-1:0]        time_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [scc_pkg::BinIdxWidth-1:0]          bin_index_o,
  output logic [scc_pkg::CountWidth-1:0]           pair_count_o,
  output logic                                     last_bin_o,
  output logic                                     no_bins_o
);
  import scc_pkg::*;

  localparam int unsigned RW =
    $clog2(MAX_REFERENCE_SPIKES) > 0 ? $clog2(MAX_REFERENCE_SPIKES) : 1;
  localparam int unsigned TW =
    $clog2(MAX_TARGET_SPIKES) > 0 ? $clog2(MAX_TARGET_SPIKES) : 1;
  localparam int unsigned ED = MAX_BINS + 1;
  localparam int unsigned EW = $clog2(ED);
  localparam int unsigned RC = $clog2(MAX_REFERENCE_SPIKES + 1);
  localparam int unsigned TC = $clog2(MAX_TARGET_SPIKES + 1);
  localparam int unsigned EC = $clog2(ED + 1);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SEdgeA = 7'b0000010,
    SEdgeB = 7'b0000100,
    SRef   = 7'b0001000,
    SPair  = 7'b0010000,
    SEmit  = 7'b0100000,
    SNoBin = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [RC-1:0] rcnt_q;
  logic [TC-1:0] tcnt_q;
  logic [EC-1:0] ecnt_q;
  logic [EW-1:0] bin_q;
  logic [RC-1:0] ri_q;
  logic [TC-1:0] tj_q;
  logic [CountWidth-1:0] total_q;
  logic signed [TIME_WIDTH-1:0] elo_q, ehi_q;
  logic signed [TIME_WIDTH:0] wlo_q, whi_q;
  logic tvalid_q;

  logic acc;
  assign in_ready_o = (state_q == SIdle) && !out_valid_o;
  assign acc = in_valid_i && in_ready_o;

  logic ref_we, tgt_we, edg_we;
  assign ref_we = acc && opcode_i == OpLoadRef && rcnt_q < RC'(MAX_REFERENCE_SPIKES);
  assign tgt_we = acc && opcode_i == OpLoadTgt && tcnt_q < TC'(MAX_TARGET_SPIKES);
  assign edg_we = acc && opcode_i == OpLoadEdge && ecnt_q < EC'(ED);

  logic [RW-1:0] rraddr;
  logic [TW-1:0] traddr;
  logic [EW-1:0] eraddr;
  logic [TIME_WIDTH-1:0] rdat, tdat, edat;

  scc_ram #(.Width(TIME_WIDTH), .Depth(MAX_REFERENCE_SPIKES)) u_ref (
    .clk_i, .we_i(ref_we), .waddr_i(rcnt_q[RW-1:0]), .wdata_i(time_value_i),
    .raddr_i(rraddr), .rdata_o(rdat));
  scc_ram #(.Width(TIME_WIDTH), .Depth(MAX_TARGET_SPIKES)) u_tgt (
    .clk_i, .we_i(tgt_we), .waddr_i(tcnt_q[TW-1:0]), .wdata_i(time_value_i),
    .raddr_i(traddr), .rdata_o(tdat));
  scc_ram #(.Width(TIME_WIDTH), .Depth(ED)) u_edg (
    .clk_i, .we_i(edg_we), .waddr_i(ecnt_q[EW-1:0]), .wdata_i(time_value_i),
    .raddr_i(eraddr), .rdata_o(edat));

  logic [EC-1:0] nbins;
  assign nbins = ecnt_q - EC'(1);
  logic last_ref, last_tgt, last_bin_w;
  assign last_ref = (ri_q + RC'(1)) >= rcnt_q;
  assign last_tgt = (tj_q + TC'(1)) >= tcnt_q;
  assign last_bin_w = EC'(bin_q) + EC'(1) == nbins;

  logic pair_done;
  assign pair_done = state_q == SPair && tvalid_q && last_tgt && last_ref;

  logic out_load;
  assign out_load = (state_q == SEmit || state_q == SNoBin) && (!out_valid_o || out_ready_i);

  always_comb begin
    eraddr = bin_q;
    if (state_q == SEdgeA || state_q == SEmit) eraddr = bin_q + EW'(1);
    rraddr = ri_q[RW-1:0];
    traddr = tj_q[TW-1:0];
    if (state_q == SPair && tvalid_q) begin
      if (!last_tgt) traddr = tj_q[TW-1:0] + TW'(1);
      else if (!last_ref) rraddr = ri_q[RW-1:0] + RW'(1);
    end
  end

  logic signed [TIME_WIDTH:0] x;
  logic hit;
  assign x = {tdat[TIME_WIDTH-1], tdat};
  assign hit = tvalid_q && x >= wlo_q && x < whi_q;

  logic [CountWidth-1:0] total_n;
  assign total_n = (hit && total_q != CountMax) ? total_q + CountWidth'(1) : total_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (acc && opcode_i == OpCompute) begin
        state_d = (ecnt_q < EC'(2)) ? SNoBin : SEdgeA;
      end
      SEdgeA: state_d = SEdgeB;
      SEdgeB: state_d = SRef;
      SRef: state_d = (rcnt_q == '0 || tcnt_q == '0) ? SEmit : SPair;
      SPair: if (pair_done) state_d = SEmit;
      SEmit: if (!out_valid_o || out_ready_i) state_d = last_bin_w ? SIdle : SEdgeA;
      SNoBin: if (!out_valid_o || out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  logic tvalid_d;
  assign tvalid_d = (state_q == SRef && state_d == SPair) ||
                    (state_q == SPair && (!tvalid_q || !last_tgt));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rcnt_q <= '0;
      tcnt_q <= '0;
      ecnt_q <= '0;
      bin_q <= '0;
      ri_q <= '0;
      tj_q <= '0;
      tvalid_q <= 1'b0;
      out_valid_o <= 1'b0;
      bin_index_o <= '0;
      pair_count_o <= '0;
      last_bin_o <= 1'b0;
      no_bins_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ref_we) rcnt_q <= rcnt_q + RC'(1);
      if (tgt_we) tcnt_q <= tcnt_q + TC'(1);
      if (edg_we) ecnt_q <= ecnt_q + EC'(1);
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      tvalid_q <= tvalid_d;
      case (state_q)
        SIdle: begin
          bin_q <= '0;
        end
        SEdgeA: begin
          ri_q <= '0;
          tj_q <= '0;
        end
        SPair: begin
          if (tvalid_q) begin
            if (!last_tgt) begin
              tj_q <= tj_q + TC'(1);
            end else if (!last_ref) begin
              tj_q <= '0;
              ri_q <= ri_q + RC'(1);
            end
          end
        end
        SEmit: if (out_load) begin
          bin_index_o <= BinIdxWidth'(bin_q);
          pair_count_o <= total_q;
          last_bin_o <= last_bin_w;
          no_bins_o <= 1'b0;
          bin_q <= bin_q + EW'(1);
          if (last_bin_w) begin
            rcnt_q <= '0;
            tcnt_q <= '0;
            ecnt_q <= '0;
          end
        end
        SNoBin: if (out_load) begin
          bin_index_o <= '0;
          pair_count_o <= '0;
          last_bin_o <= 1'b1;
          no_bins_o <= 1'b1;
          rcnt_q <= '0;
          tcnt_q <= '0;
          ecnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SEdgeA: begin
        elo_q <= edat;
        total_q <= '0;
      end
      SEdgeB: ehi_q <= edat;
      SRef: begin
        wlo_q <= {rdat[TIME_WIDTH-1], rdat} + {elo_q[TIME_WIDTH-1], elo_q};
        whi_q <= {rdat[TIME_WIDTH-1], rdat} + {ehi_q[TIME_WIDTH-1], ehi_q};
      end
      SPair: begin
        total_q <= total_n;
        if (!tvalid_q) begin
          wlo_q <= {rdat[TIME_WIDTH-1], rdat} + {elo_q[TIME_WIDTH-1], elo_q};
          whi_q <= {rdat[TIME_WIDTH-1], rdat} + {ehi_q[TIME_WIDTH-1], ehi_q};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/scc_checker.sv =====
// Port-level checker for the spike cross-correlogram block, with its bind.
`default_nettype none
module scc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic last_bin_o,
  input wire logic no_bins_o,
  input wire logic [5:0] bin_index_o,
  input wire logic [20:0] pair_count_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pair_count_o))
    else $error("result changed while stalled");
  a_nobin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_bins_o |-> last_bin_o && bin_index_o == 6'd0 && pair_count_o == '0)
    else $error("bad no-bins result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with result pending");
endmodule

bind spike_cross_correlogram scc_checker u_scc_checker (.*);
`default_nettype wire

// ===== dv/spike_cross_correlogram_test.sv =====
// Self-checking testbench for the spike cross-correlogram block, driven by directed and random beats.
`timescale 1ns / 1ps
module spike_cross_correlogram_test;
  import scc_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             opcode_i = OpLoadRef;
  logic signed [31:0]     time_value_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [BinIdxWidth-1:0] bin_index_o;
  logic [CountWidth-1:0]  pair_count_o;
  logic                   last_bin_o;
  logic                   no_bins_o;

  typedef struct packed {
    logic [BinIdxWidth-1:0] bin;
    logic [CountWidth-1:0]  count;
    logic                   last;
    logic                   none;
  } bin_result_t;

  logic signed [31:0] ref_times[$];
  logic signed [31:0] tgt_times[$];
  logic signed [31:0] edges[$];
  bin_result_t        pending_bins[$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  int unsigned        beats_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        computes = 0;
  int unsigned        max_gap = 14;
  int unsigned        max_stall = 14;

  spike_cross_correlogram u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .time_value_i,
    .out_valid_o, .out_ready_i, .bin_index_o, .pair_count_o, .last_bin_o, .no_bins_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic predict_histogram();
    int unsigned nb;
    logic signed [32:0] lo, hi, x;
    logic [CountWidth-1:0] total;
    bin_result_t r;
    if (edges.size() < 2) begin
      r = '{bin: '0, count: '0, last: 1'b1, none: 1'b1};
      pending_bins.push_back(r);
    end else begin
      nb = edges.size() - 1;
      for (int t = 0; t < nb; t++) begin
        total = '0;
        foreach (ref_times[i]) begin
          lo = 33'(ref_times[i]) + 33'(edges[t]);
          hi = 33'(ref_times[i]) + 33'(edges[t+1]);
          foreach (tgt_times[j]) begin
            x = 33'(tgt_times[j]);
            if (x >= lo && x < hi && total != CountMax) total++;
          end
        end
        r = '{bin: t[BinIdxWidth-1:0], count: total, last: (t + 1 == nb), none: 1'b0};
        pending_bins.push_back(r);
      end
    end
    ref_times.delete();
    tgt_times.delete();
    edges.delete();
  endtask

  task automatic send_beat(input opcode_e op, input logic signed [31:0] tv);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    time_value_i <= tv;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    case (op)
      OpLoadRef:  if (ref_times.size() < MaxRefSpikes) ref_times.push_back(tv);
      OpLoadTgt:  if (tgt_times.size() < MaxTgtSpikes) tgt_times.push_back(tv);
      OpLoadEdge: if (edges.size() < MaxBinsDef + 1) edges.push_back(tv);
      default: begin
        computes++;
        predict_histogram();
      end
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    bin_result_t e;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result bin %0d count %0d", $time, bin_index_o, pair_count_o);
        errors++;
      end else begin
        e = pending_bins.pop_front();
        if (e.bin !== bin_index_o || e.count !== pair_count_o || e.last !== last_bin_o ||
            e.none !== no_bins_o) begin
          $display("%0t: expected bin %0d count %0d last %0b none %0b, got %0d %0d %0b %0b",
                   $time, e.bin, e.count, e.last, e.none,
                   bin_index_o, pair_count_o, last_bin_o, no_bins_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned s;
    forever begin
      s = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(max_stall, 0);
      out_ready_i <= 1'b0;
      repeat (s) @(posedge clk_i);
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic test_no_edges();
    send_beat(OpCompute, '0);
    send_beat(OpLoadEdge, 32'sd5);
    send_beat(OpLoadRef, 32'sd1);
    send_beat(OpCompute, 32'sh7fffffff);
    drain();
  endtask

  task automatic test_extremes();
    send_beat(OpLoadRef, 32'sh7fffffff);
    send_beat(OpLoadRef, 32'sh80000000);
    send_beat(OpLoadRef, 32'sd0);
    send_beat(OpLoadTgt, 32'sh7fffffff);
    send_beat(OpLoadTgt, 32'sh80000000);
    send_beat(OpLoadTgt, -32'sd1);
    send_beat(OpLoadEdge, 32'sh80000000);
    send_beat(OpLoadEdge, -32'sd1);
    send_beat(OpLoadEdge, 32'sd1);
    send_beat(OpLoadEdge, 32'sh7fffffff);
    send_beat(OpLoadEdge, 32'sd0);
    send_beat(OpCompute, -32'sd1);
    drain();
  endtask

  task automatic test_empty_spikes();
    send_beat(OpLoadEdge, -32'sd10);
    send_beat(OpLoadEdge, 32'sd10);
    send_beat(OpLoadTgt, 32'sd3);
    send_beat(OpCompute, '0);
    drain();
  endtask

  task automatic test_full_edges();
    max_gap = 0;
    for (int k = 0; k < MaxBinsDef + 3; k++) send_beat(OpLoadEdge, 32'(k * 4 - 100));
    send_beat(OpLoadRef, 32'sd0);
    send_beat(OpLoadTgt, 32'sd7);
    send_beat(OpCompute, '0);
    drain();
    max_gap = 14;
  endtask

  task automatic test_random();
    int unsigned nref, ntgt, ned, span;
    logic signed [31:0] base;
    for (int set = 0; beats_sent < 300; set++) begin
      if (set % 5 == 0) begin
        max_gap = 0;
        max_stall = 0;
      end else begin
        max_gap = 14;
        max_stall = 14;
      end
      span = ($urandom_range(3, 0) == 0) ? 32'hffffffff : $urandom_range(200, 4);
      base = (span == 32'hffffffff) ? '0 : $signed($urandom());
      if (base > 32'sh7ffff000 || base < -32'sh7ffff000) base = '0;
      nref = $urandom_range(8, 0);
      ntgt = $urandom_range(12, 0);
      ned = ($urandom_range(7, 0) == 0) ? $urandom_range(1, 0) : $urandom_range(8, 2);
      for (int k = 0; k < nref + ntgt + ned; k++) begin
        int unsigned pick;
        logic signed [31:0] v;
        pick = $urandom_range(nref + ntgt + ned - 1, 0);
        v = (span == 32'hffffffff) ? $signed($urandom())
                                   : base + $signed(32'($urandom_range(span, 0)));
        if (pick < nref) send_beat(OpLoadRef, v);
        else if (pick < nref + ntgt) send_beat(OpLoadTgt, v);
        else send_beat(OpLoadEdge, (span == 32'hffffffff) ? v
                                   : $signed(32'($urandom_range(span, 0))) - $signed(span / 2));
      end
      if (set % 9 == 4) drain();
      send_beat(OpCompute, $signed($urandom()));
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_edges();
    test_extremes();
    test_empty_spikes();
    test_full_edges();
    test_random();
    $display("Sent %0d beats with %0d compute requests; checked %0d bin results.",
             beats_sent, computes, results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== spike_cross_correlogram.f =====
design/scc_pkg.sv
design/scc_ram.sv
design/spike_cross_correlogram.sv
design/scc_checker.sv
dv/spike_cross_correlogram_test.sv
